FILE: design/blar_pkg.sv
package blar_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned DataW    = 32;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned IndexW   = 6;
  localparam int unsigned StatusW  = 2;

  localparam logic [ModeW-1:0] ModeAppend = 2'd0;
  localparam logic [ModeW-1:0] ModeRemove = 2'd1;
  localparam logic [ModeW-1:0] ModeRead   = 2'd2;

  localparam logic [StatusW-1:0] StatusOk    = 2'd0;
  localparam logic [StatusW-1:0] StatusFull  = 2'd1;
  localparam logic [StatusW-1:0] StatusRange = 2'd2;

  // request held steady for the whole pass
  typedef struct packed {
    logic [ModeW-1:0]        mode;
    logic signed [DataW-1:0] value;
    logic [IndexW-1:0]       index;
  } cmd_t;

  // token that walks the chain one cell per cycle
  typedef struct packed {
    logic                    tok;
    logic                    hit;
    logic signed [DataW-1:0] data;
  } wave_t;

endpackage

FILE: design/bounded_list_append_remove.sv
// Ordered list of signed 32-bit entries in a row of Capacity cells, one entry
// per cell. Every request (append, remove first match, read at index) sends a
// token down the row one cell per cycle; each cell acts on the request as the
// token passes, a removal pulling the upper neighbor's entry down. A request
// accepted on start takes Capacity + 2 cycles: the result beat appears on
// valid_o Capacity + 1 cycles after acceptance, for one cycle only, and busy
// falls in that same cycle so the next start may be taken then (66 cycles per
// request at the default Capacity of 64). The receiver cannot stall results;
// it must capture every valid_o beat. Mode 3 passes through with no effect.
module bounded_list_append_remove #(
  parameter int unsigned Capacity = blar_pkg::Capacity,
  localparam int unsigned CntW    = $clog2(Capacity + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [blar_pkg::ModeW-1:0]          mode_i,
  input  logic signed [blar_pkg::DataW-1:0]   value_i,
  input  logic [blar_pkg::IndexW-1:0]         index_i,
  output logic                                valid_o,
  output logic signed [blar_pkg::DataW-1:0]   read_value_o,
  output logic [CntW-1:0]                     count_o,
  output logic                                found_o,
  output logic [blar_pkg::StatusW-1:0]        status_o
);

  blar_pkg::cmd_t                    cmd_q;
  logic                              go_q;
  logic                              busy_q, busy_d;
  logic [CntW-1:0]                   count_q, count_d;
  logic                              valid_q, valid_d;
  logic signed [blar_pkg::DataW-1:0] rd_q, rd_d;
  logic                              found_q, found_d;
  logic [blar_pkg::StatusW-1:0]      status_q, status_d;
  logic                              accept;
  logic                              done;

  blar_pkg::wave_t                   wave [Capacity+1];
  logic signed [blar_pkg::DataW-1:0] entry [Capacity+1];

  assign accept = start && !busy_q;

  assign wave[0].tok  = go_q;
  assign wave[0].hit  = 1'b0;
  assign wave[0].data = '0;
  assign entry[Capacity] = '0;

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    blar_cell #(
      .Pos  (g),
      .CntW (CntW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd_q),
      .count_i      (count_q),
      .wave_i       (wave[g]),
      .next_entry_i (entry[g+1]),
      .wave_o       (wave[g+1]),
      .entry_o      (entry[g])
    );
  end

  assign done = wave[Capacity].tok;

  always_comb begin
    busy_d   = busy_q;
    count_d  = count_q;
    valid_d  = 1'b0;
    rd_d     = '0;
    found_d  = 1'b0;
    status_d = blar_pkg::StatusOk;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (done) begin
      busy_d  = 1'b0;
      valid_d = 1'b1;
      case (cmd_q.mode)
        blar_pkg::ModeAppend: begin
          if (count_q == CntW'(Capacity)) begin
            status_d = blar_pkg::StatusFull;
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
        blar_pkg::ModeRemove: begin
          found_d = wave[Capacity].hit;
          if (wave[Capacity].hit) begin
            count_d = count_q - CntW'(1);
          end
        end
        blar_pkg::ModeRead: begin
          // hit is only raised for an index inside the list
          if (wave[Capacity].hit) begin
            rd_d = wave[Capacity].data;
          end else begin
            status_d = blar_pkg::StatusRange;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.mode  <= mode_i;
      cmd_q.value <= value_i;
      cmd_q.index <= index_i;
    end
    rd_q     <= rd_d;
    found_q  <= found_d;
    status_q <= status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q    <= 1'b0;
      busy_q  <= 1'b0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      go_q    <= accept;
      busy_q  <= busy_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  assign busy         = busy_q;
  assign valid_o      = valid_q;
  assign read_value_o = rd_q;
  assign count_o      = count_q;
  assign found_o      = found_q;
  assign status_o     = status_q;

endmodule

FILE: design/blar_cell.sv
module blar_cell #(
  parameter int unsigned Pos  = 0,
  parameter int unsigned CntW = 7
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  blar_pkg::cmd_t                    cmd_i,
  input  logic [CntW-1:0]                   count_i,
  input  blar_pkg::wave_t                   wave_i,
  input  logic signed [blar_pkg::DataW-1:0] next_entry_i,
  output blar_pkg::wave_t                   wave_o,
  output logic signed [blar_pkg::DataW-1:0] entry_o
);

  localparam int unsigned CmpW = (CntW > blar_pkg::IndexW) ? CntW : blar_pkg::IndexW;

  logic signed [blar_pkg::DataW-1:0] entry_q, entry_d;
  blar_pkg::wave_t                   wave_q, wave_d;
  logic                              active;
  logic                              in_list;
  logic                              hit_here;
  logic                              is_remove;
  logic                              is_read;
  logic                              is_append;

  assign active    = wave_i.tok;
  assign in_list   = CntW'(Pos) < count_i;
  assign is_remove = cmd_i.mode == blar_pkg::ModeRemove;
  assign is_read   = cmd_i.mode == blar_pkg::ModeRead;
  assign is_append = cmd_i.mode == blar_pkg::ModeAppend;

  // first match along the chain only; later cells see hit already set
  assign hit_here = active && in_list && !wave_i.hit &&
                    ((is_remove && (entry_q == cmd_i.value)) ||
                     (is_read && (CmpW'(Pos) == CmpW'(cmd_i.index))));

  always_comb begin
    entry_d = entry_q;
    if (active && is_remove && (wave_i.hit || hit_here)) begin
      entry_d = next_entry_i;  // close the gap
    end else if (active && is_append && (CntW'(Pos) == count_i)) begin
      entry_d = cmd_i.value;
    end
    wave_d.tok  = active;
    wave_d.hit  = wave_i.hit || hit_here;
    wave_d.data = (hit_here && is_read) ? entry_q : wave_i.data;
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= '0;
    end else begin
      wave_q <= wave_d;
    end
  end

  assign wave_o  = wave_q;
  assign entry_o = entry_q;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CntW = $clog2(blar_pkg::Capacity + 1);
  localparam logic [blar_pkg::ModeW-1:0] ModeUnused = 2'd3;
  localparam int RandomItems = 1350;
  localparam int CycleLimit = 600_000;

  typedef struct {
    logic signed [blar_pkg::DataW-1:0] read_value;
    logic [CntW-1:0]                   count;
    logic                              found;
    logic [blar_pkg::StatusW-1:0]      status;
  } reply_t;

  // Shadow copy of the list; each accepted request queues the reply it must produce.
  class list_shadow;
    logic signed [blar_pkg::DataW-1:0] held[blar_pkg::Capacity];
    int held_count;
    reply_t due[$];
    int unsigned errors;

    function new();
      held_count = 0;
      errors = 0;
    endfunction

    function int size();
      return held_count;
    endfunction

    function logic signed [blar_pkg::DataW-1:0] entry(int i);
      return held[i];
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void flag(string what, longint want, longint got);
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    endfunction

    function void accept_request(logic [blar_pkg::ModeW-1:0] mode,
                                 logic signed [blar_pkg::DataW-1:0] value,
                                 logic [blar_pkg::IndexW-1:0] index);
      reply_t r;
      int pos;
      r.read_value = '0;
      r.found = 1'b0;
      r.status = blar_pkg::StatusOk;
      pos = -1;
      case (mode)
        blar_pkg::ModeAppend: begin
          if (held_count >= blar_pkg::Capacity) begin
            r.status = blar_pkg::StatusFull;
          end else begin
            held[held_count] = value;
            held_count++;
          end
        end
        blar_pkg::ModeRemove: begin
          for (int i = 0; i < held_count; i++)
            if (pos < 0 && held[i] == value) pos = i;
          if (pos >= 0) begin
            // close the gap left by the first match
            for (int i = pos; i + 1 < held_count; i++) held[i] = held[i + 1];
            held_count--;
            r.found = 1'b1;
          end
        end
        blar_pkg::ModeRead: begin
          if (int'(index) < held_count) r.read_value = held[index];
          else r.status = blar_pkg::StatusRange;
        end
        default: ;
      endcase
      r.count = held_count[CntW-1:0];
      due.push_back(r);
    endfunction

    function void check_reply(logic signed [blar_pkg::DataW-1:0] read_value,
                              logic [CntW-1:0] count, logic found,
                              logic [blar_pkg::StatusW-1:0] status);
      reply_t r;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: result beat with no request pending", $time);
        return;
      end
      r = due.pop_front();
      if (read_value !== r.read_value) flag("read_value", r.read_value, read_value);
      if (count !== r.count) flag("count", r.count, count);
      if (found !== r.found) flag("found", r.found, found);
      if (status !== r.status) flag("status", r.status, status);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [blar_pkg::ModeW-1:0] mode_i = blar_pkg::ModeAppend;
  logic signed [blar_pkg::DataW-1:0] value_i = '0;
  logic [blar_pkg::IndexW-1:0] index_i = '0;
  logic valid_o;
  logic signed [blar_pkg::DataW-1:0] read_value_o;
  logic [CntW-1:0] count_o;
  logic found_o;
  logic [blar_pkg::StatusW-1:0] status_o;

  list_shadow shadow;
  int cycles = 0;
  int items_sent = 0;

  bounded_list_append_remove dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .value_i      (value_i),
    .index_i      (index_i),
    .valid_o      (valid_o),
    .read_value_o (read_value_o),
    .count_o      (count_o),
    .found_o      (found_o),
    .status_o     (status_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) shadow.check_reply(read_value_o, count_o, found_o, status_o);
  end

  // Holds start high until the beat is taken; start stays high for a following send.
  task automatic send(logic [blar_pkg::ModeW-1:0] mode,
                      logic signed [blar_pkg::DataW-1:0] value,
                      logic [blar_pkg::IndexW-1:0] index);
    start <= 1'b1;
    mode_i <= mode;
    value_i <= value;
    index_i <= index;
    do @(posedge clk_i); while (busy);
    shadow.accept_request(mode, value, index);
    items_sent++;
  endtask

  task automatic idle(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Small pool gives duplicates so remove has to pick the first one.
  function automatic logic signed [blar_pkg::DataW-1:0] append_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return $signed($urandom_range(0, 5)) - 2;
    if (roll == 4) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    int burst;
    int roll;
    bit filling;
    logic signed [blar_pkg::DataW-1:0] v;
    logic [blar_pkg::IndexW-1:0] ix;

    shadow = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, extremes, first-match removal, out-of-range reads
    send(blar_pkg::ModeRead, 32'sd0, 6'd0);
    send(blar_pkg::ModeRemove, 32'sd5, 6'd0);
    send(ModeUnused, -32'sd1, 6'd63);
    send(blar_pkg::ModeAppend, 32'sh8000_0000, 6'd0);
    send(blar_pkg::ModeAppend, 32'sh7fff_ffff, 6'd63);
    send(blar_pkg::ModeAppend, 32'sd0, 6'd0);
    send(blar_pkg::ModeAppend, -32'sd1, 6'd0);
    send(blar_pkg::ModeAppend, 32'sh7fff_ffff, 6'd0);
    send(blar_pkg::ModeRead, 32'sd0, 6'd0);
    send(blar_pkg::ModeRead, 32'sd0, 6'd4);
    send(blar_pkg::ModeRead, 32'sd0, 6'd5);
    send(blar_pkg::ModeRead, -32'sd1, 6'd63);
    send(blar_pkg::ModeRemove, 32'sh7fff_ffff, 6'd0);
    send(blar_pkg::ModeRead, 32'sd0, 6'd1);
    send(blar_pkg::ModeRead, 32'sd0, 6'd3);
    send(blar_pkg::ModeRemove, 32'sd12345, 6'd0);
    send(blar_pkg::ModeRemove, 32'sh8000_0000, 6'd0);
    send(blar_pkg::ModeRemove, 32'sh7fff_ffff, 6'd0);
    send(blar_pkg::ModeRead, 32'sd0, 6'd2);
    send(ModeUnused, 32'sh7fff_ffff, 6'd0);
    send(blar_pkg::ModeRemove, 32'sd0, 6'd0);
    send(blar_pkg::ModeRemove, -32'sd1, 6'd0);
    send(blar_pkg::ModeRead, 32'sd0, 6'd0);
    idle($urandom_range(1, 4));

    // random: swing between filling to the top and draining to empty
    filling = 1'b1;
    items_sent = 0;
    while (items_sent < RandomItems) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      repeat (burst) begin
        roll = $urandom_range(0, 99);
        v = $urandom;
        ix = $urandom_range(0, 63);
        if (roll < (filling ? 65 : 20)) begin
          send(blar_pkg::ModeAppend, append_value(), ix);
        end else if (roll < (filling ? 80 : 70)) begin
          if (shadow.size() > 0 && $urandom_range(0, 3) != 0)
            v = shadow.entry($urandom_range(0, shadow.size() - 1));
          else
            v = append_value();
          send(blar_pkg::ModeRemove, v, ix);
        end else if (roll < 97) begin
          if (shadow.size() > 0 && $urandom_range(0, 4) != 0)
            ix = $urandom_range(0, shadow.size() - 1);
          send(blar_pkg::ModeRead, v, ix);
        end else begin
          send(ModeUnused, v, ix);
        end
        if (filling && shadow.size() == blar_pkg::Capacity && $urandom_range(0, 5) == 0)
          filling = 1'b0;
        else if (!filling && shadow.size() == 0 && $urandom_range(0, 3) == 0)
          filling = 1'b1;
        else if ($urandom_range(0, 199) == 0)
          filling = !filling;
      end
      if ($urandom_range(0, 2) == 0) idle($urandom_range(5, 80));
      else idle($urandom_range(1, 4));
    end
    start <= 1'b0;

    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (blar_pkg::Capacity + 4) @(posedge clk_i);
    if (shadow.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: bounded_list_append_remove.f
design/blar_pkg.sv
design/blar_cell.sv
design/bounded_list_append_remove.sv
tb/testbench.sv
